/* design/argt_pkg.sv */
// ----------------------------------------------------------------------------
// argt_pkg
// Shared types and constants of the address reservation guard table.
// ----------------------------------------------------------------------------
`default_nettype none

package argt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int POINTER_WIDTH = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int ADDR_W     = 64;
    localparam int BTYPE_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 72;

    localparam logic [ADDR_W-1:0] PTR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - POINTER_WIDTH);

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_DUP     = 2'd1,
        VERDICT_BLOCKED = 2'd2
    } t_verdict;

    localparam logic [STATUS_W-1:0] STATUS_SUCCESS     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAILED      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_CHANGE   = 2'd3;

    localparam logic MODE_RESERVE = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

`default_nettype wire

/* design/argt_ctrl.sv */
// ----------------------------------------------------------------------------
// argt_ctrl
// Controller: sequences capture, table scan, commit and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module argt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire argt_pkg::t_status i_status,
    output argt_pkg::t_cmd         o_cmd
);
    import argt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.capture = o_in_ready && i_in_valid;
        o_cmd.rd_en   = (r_state == S_SCAN);
        o_cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_LAST;
            end
            S_LAST: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.commit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/argt_dpath.sv */
// ----------------------------------------------------------------------------
// argt_dpath
// Datapath: request registers, entry memory, scan compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module argt_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire argt_pkg::t_cmd                  i_cmd,
    output argt_pkg::t_status                    o_status,
    input  wire logic                            i_mode,
    input  wire logic [argt_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [argt_pkg::ADDR_W-1:0]     i_replacement,
    input  wire logic [argt_pkg::BTYPE_W-1:0]    i_backend_type,
    input  wire logic [argt_pkg::STATUS_W-1:0]   i_update_status,
    input  wire logic [argt_pkg::ADDR_W-1:0]     i_orig_value,
    output logic [argt_pkg::OUT_DATA_W-1:0]      o_result
);
    import argt_pkg::*;

    logic                r_req_mode;
    logic [ADDR_W-1:0]   r_req_addr;
    logic [ADDR_W-1:0]   r_req_repl;
    logic [BTYPE_W-1:0]  r_req_btype;
    logic [STATUS_W-1:0] r_req_status;
    logic [ADDR_W-1:0]   r_req_orig;

    logic [ADDR_W-1:0]   mem_addr  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   mem_repl  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   mem_orig  [TABLE_ENTRIES];
    logic [BTYPE_W-1:0]  mem_btype [TABLE_ENTRIES];
    logic                mem_taint [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] r_valid;

    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_valid;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [ADDR_W-1:0]   r_rd_repl;
    logic [ADDR_W-1:0]   r_rd_orig;
    logic [BTYPE_W-1:0]  r_rd_btype;
    logic                r_rd_taint;

    logic                r_hit_found;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_hit_repl_eq;
    logic                r_hit_btype_eq;
    logic                r_hit_taint;
    logic [ADDR_W-1:0]   r_hit_orig;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;

    t_verdict            r_verdict;
    logic [ADDR_W-1:0]   r_orig_out;
    logic                r_written;
    logic                r_stored;

    logic                cmp_match;
    logic                cmp_free;

    t_verdict            n_verdict;
    logic [ADDR_W-1:0]   n_orig_out;
    logic                n_written;
    logic                n_stored;
    logic [IDX_W-1:0]    wr_idx;
    logic                we_claim;
    logic                we_orig;
    logic                we_taint;
    logic                valid_clr;

    assign o_status.scan_last = (r_idx == IDX_W'(TABLE_ENTRIES - 1));

    assign cmp_match = r_cmp_valid && r_valid[r_cmp_idx] && (r_rd_addr == r_req_addr);
    assign cmp_free  = r_cmp_valid && !r_valid[r_cmp_idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_mode   <= i_mode;
            r_req_addr   <= i_address & PTR_MASK;
            r_req_repl   <= i_replacement & PTR_MASK;
            r_req_btype  <= i_backend_type;
            r_req_status <= i_update_status;
            r_req_orig   <= i_orig_value & PTR_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_valid  <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.rd_en;
            if (i_cmd.capture) begin
                r_idx        <= '0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (i_cmd.rd_en) r_idx <= r_idx + 1'b1;
                if (cmp_match && !r_hit_found) r_hit_found <= 1'b1;
                if (cmp_free && !r_free_found) r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) r_cmp_idx <= r_idx;
        if (cmp_match && !r_hit_found) begin
            r_hit_idx      <= r_cmp_idx;
            r_hit_repl_eq  <= (r_rd_repl == r_req_repl);
            r_hit_btype_eq <= (r_rd_btype == r_req_btype);
            r_hit_taint    <= r_rd_taint;
            r_hit_orig     <= r_rd_orig;
        end
        if (cmp_free && !r_free_found) r_free_idx <= r_cmp_idx;
    end

    always_comb begin
        n_verdict  = VERDICT_OK;
        n_orig_out = '0;
        n_written  = 1'b0;
        n_stored   = 1'b0;
        wr_idx     = r_hit_idx;
        we_claim   = 1'b0;
        we_orig    = 1'b0;
        we_taint   = 1'b0;
        valid_clr  = 1'b0;
        case (r_req_mode)
            MODE_RESERVE: begin
                if (r_hit_found) begin
                    if (r_hit_repl_eq) begin
                        n_verdict  = VERDICT_DUP;
                        n_orig_out = r_hit_orig;
                        n_written  = 1'b1;
                    end else if (r_hit_taint || !r_hit_btype_eq) begin
                        n_verdict = VERDICT_BLOCKED;
                    end
                end else if (r_free_found) begin
                    wr_idx    = r_free_idx;
                    we_claim  = i_cmd.commit;
                    n_written = 1'b1;
                    n_stored  = 1'b1;
                end
            end
            MODE_UPDATE: begin
                if (r_hit_found) begin
                    case (r_req_status)
                        STATUS_SUCCESS:     we_orig   = i_cmd.commit;
                        STATUS_FAILED:      we_taint  = i_cmd.commit;
                        STATUS_UNSUPPORTED: valid_clr = i_cmd.commit;
                        STATUS_NO_CHANGE:   ;
                        default:            ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_claim) begin
            mem_addr[wr_idx]  <= r_req_addr;
            mem_repl[wr_idx]  <= r_req_repl;
            mem_btype[wr_idx] <= r_req_btype;
        end
        if (we_claim) begin
            mem_orig[wr_idx] <= '0;
        end else if (we_orig) begin
            mem_orig[wr_idx] <= r_req_orig;
        end
        if (we_claim) begin
            mem_taint[wr_idx] <= 1'b0;
        end else if (we_taint) begin
            mem_taint[wr_idx] <= 1'b1;
        end
        if (i_cmd.rd_en) begin
            r_rd_addr  <= mem_addr[r_idx];
            r_rd_repl  <= mem_repl[r_idx];
            r_rd_orig  <= mem_orig[r_idx];
            r_rd_btype <= mem_btype[r_idx];
            r_rd_taint <= mem_taint[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we_claim) begin
            r_valid[wr_idx] <= 1'b1;
        end else if (valid_clr) begin
            r_valid[wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_verdict  <= n_verdict;
            r_orig_out <= n_orig_out;
            r_written  <= n_written;
            r_stored   <= n_stored;
        end
    end

    assign o_result = {
        (OUT_DATA_W - 68)'(0), r_stored, r_written, r_orig_out, r_verdict
    };

endmodule

`default_nettype wire

/* design/address_reservation_guard_table.sv */
// ----------------------------------------------------------------------------
// address_reservation_guard_table
// Table of address reservations answering reserve and update transactions.
// ----------------------------------------------------------------------------
// Each input transaction gives exactly one result transaction. The block works
// on one transaction at a time: after acceptance it sweeps the entry memory one
// entry per cycle through its single read port, then passes through a
// last-compare state (S_LAST) and a commit state (S_EXEC) before it can accept
// the next transaction. The result sits in an output register, so a new
// transaction is taken while an earlier result still waits; the commit stalls
// only when a second result would overwrite one not yet taken. The lowest
// valid entry with the same address answers; a claim takes the lowest free
// entry, and a reserve into a full table answers ok without storing.
// ----------------------------------------------------------------------------
`default_nettype none

module address_reservation_guard_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // address[63:0], replacement[127:64], backend_type[135:128],
    // update_status[137:136], orig_value[201:138], zero pad[207:202]
    input  wire logic [argt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // verdict[1:0], orig_out[65:2], orig_written[66], entry_stored[67],
    // zero pad[71:68]
    output logic [argt_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import argt_pkg::*;

    t_cmd    cmd;
    t_status status;

    argt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    argt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (s_axis_tuser),
        .i_address       (s_axis_tdata[63:0]),
        .i_replacement   (s_axis_tdata[127:64]),
        .i_backend_type  (s_axis_tdata[135:128]),
        .i_update_status (s_axis_tdata[137:136]),
        .i_orig_value    (s_axis_tdata[201:138]),
        .o_result        (m_axis_tdata)
    );

endmodule

`default_nettype wire
